FILE: rtl/lennard_jones_force_sum_macros.svh
// ----------------------------------------------------------------------------
// lennard_jones_force_sum_macros.svh
// assertion shorthands shared by the force summation block
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_FORCE_SUM_MACROS_SVH
`define LENNARD_JONES_FORCE_SUM_MACROS_SVH

// same-cycle implication on clk, quiet during reset
`define LJFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, quiet during reset
`define LJFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ljfs_pkg.sv
// ----------------------------------------------------------------------------
// ljfs_pkg
// types, codes and saturation helper for the lennard-jones force summation
// ----------------------------------------------------------------------------
package ljfs_pkg;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register index as decoded from paddr[2]
    localparam logic REG_ATOM_COUNT = 1'b0;

    // arithmetic constants
    localparam logic [63:0] R2SAFE  = 64'd43;
    localparam logic [63:0] MAGMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] IR2_NUM = 64'h8000_0000_0000_0000;
    localparam logic signed [67:0] SAT_HI = 68'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [67:0] SAT_LO = 68'shF_8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // multiplier and divider step counts
    localparam logic [2:0] MUL_LAST = 3'd4;
    localparam logic [5:0] DIV_FIRST = 6'd63;

    typedef struct packed {
        logic               operation;
        logic [5:0]         atom_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [47:0] coef_c6;
        logic signed [47:0] coef_c12;
        logic               last_query;
    } ljfs_in_t;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] energy;
        logic               last_point;
        logic               saturated;
    } ljfs_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [47:0] c6;
        logic signed [47:0] c12;
    } ljfs_atom_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ljfs_mul_sts_t;

    typedef struct packed {
        logic               clamp;
        logic signed [63:0] val;
    } ljfs_sat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_RDW,
        ST_SQ,
        ST_DIV,
        ST_POW,
        ST_GC1,
        ST_GC2,
        ST_QM,
        ST_FM,
        ST_FA,
        ST_OUT
    } ljfs_state_t;

    // clamp a widened result into signed 64 bits
    function automatic ljfs_sat_t sat64(input logic signed [67:0] v);
        ljfs_sat_t r;
        if (v > SAT_HI) begin
            r.clamp = 1'b1;
            r.val   = S64_MAX;
        end else if (v < SAT_LO) begin
            r.clamp = 1'b1;
            r.val   = S64_MIN;
        end else begin
            r.clamp = 1'b0;
            r.val   = v[63:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/ljfs_if.sv
// ----------------------------------------------------------------------------
// ljfs_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface ljfs_in_if;
    import ljfs_pkg::*;
    logic     valid;
    logic     ready;
    ljfs_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ljfs_out_if;
    import ljfs_pkg::*;
    logic      valid;
    logic      ready;
    ljfs_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ljfs_atom_mem.sv
// ----------------------------------------------------------------------------
// ljfs_atom_mem
// atom table: one write port, one registered read port
// ----------------------------------------------------------------------------
module ljfs_atom_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  ljfs_pkg::ljfs_atom_t wr_data,
    input  logic [AW-1:0]        rd_addr,
    output ljfs_pkg::ljfs_atom_t rd_data
);
    import ljfs_pkg::*;

    ljfs_atom_t mem [DEPTH];

    // write on load, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/ljfs_mul.sv
// ----------------------------------------------------------------------------
// ljfs_mul
// 64x64 unsigned multiply from four 32x32 partial products
// ----------------------------------------------------------------------------
module ljfs_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             a,
    input  logic [63:0]             b,
    output ljfs_pkg::ljfs_mul_sts_t sts,
    output logic [127:0]            prod
);
    import ljfs_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [63:0]  pp_next;
    logic [127:0] acc_reg;
    logic [127:0] pp_shift;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [1:0]   prev;

    // partial product select and alignment of the previous one
    always_comb
    begin
        a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_next = 64'(a_half) * 64'(b_half);
        prev    = cnt_reg[1:0] - 2'd1;
        case (prev)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shift = {32'd0, pp_reg, 32'd0};
            2'd3:    pp_shift = {pp_reg, 64'd0};
            default: pp_shift = '0;
        endcase
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg)
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    // operands, partial product and accumulation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg)
        begin
            pp_reg <= pp_next;
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shift;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign prod     = acc_reg;

endmodule

FILE: rtl/ljfs_div.sv
// ----------------------------------------------------------------------------
// ljfs_div
// restoring divider for 2^63 / r2, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ljfs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);
    import ljfs_pkg::*;

    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        ge;

    // one restoring step
    always_comb
    begin
        rem_sh   = {rem_reg, IR2_NUM[cnt_reg]};
        rem_sub  = rem_sh - {1'b0, den_reg};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? rem_sub[63:0] : rem_sh[63:0];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_FIRST;
            end else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/lennard_jones_force_sum.sv
// ----------------------------------------------------------------------------
// lennard_jones_force_sum
// Sums Lennard-Jones 12-6 force and energy over a table of atoms. A load
// request writes one table entry. A query request walks the first
// atom_count entries (at most MAX_ATOMS) one at a time; the work per atom
// is set by the shared 64x64 multiplier (eighteen products: three squares,
// nine coefficient powers, and per component one dR*ir2 scaling and one
// force term) and the 64-step divider for 1/r2. Loads and queries are
// handled one at a time; a finished result waits in an output register
// while the next request is accepted. The atom table has no reset: every
// entry must be loaded before a query reads it.
// ----------------------------------------------------------------------------
`include "lennard_jones_force_sum_macros.svh"

module lennard_jones_force_sum #(
    parameter int MAX_ATOMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ljfs_in_if.sink     item,
    ljfs_out_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ljfs_pkg::*;

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = $clog2(MAX_ATOMS + 1);

    // control state
    ljfs_state_t state_reg, state_next;
    logic [6:0]  atom_count_reg;
    logic        wait_reg, wait_next;
    logic        out_valid_reg, out_valid_next;

    // datapath state
    logic signed [31:0] probe_reg [3];
    logic signed [31:0] probe_next [3];
    logic [31:0]        dm_reg [3];
    logic [31:0]        dm_next [3];
    logic               dneg_reg [3];
    logic               dneg_next [3];
    logic signed [63:0] acc_reg [4];
    logic signed [63:0] acc_next [4];
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [1:0]         k_reg, k_next;
    logic [3:0]         step_reg, step_next;
    logic signed [47:0] c6_reg, c6_next;
    logic signed [47:0] c12_reg, c12_next;
    logic [63:0]        r2_reg, r2_next;
    logic [63:0]        ir2_reg, ir2_next;
    logic [63:0]        pm_reg, pm_next;
    logic signed [63:0] e6_reg, e6_next;
    logic signed [63:0] e12_reg, e12_next;
    logic signed [63:0] m6_reg, m6_next;
    logic signed [63:0] m12_reg, m12_next;
    logic signed [63:0] et_reg, et_next;
    logic [63:0]        gm_reg, gm_next;
    logic               gneg_reg, gneg_next;
    logic [63:0]        q_reg, q_next;
    logic [63:0]        fm_reg, fm_next;
    logic               fneg_reg, fneg_next;
    logic               sat_reg, sat_next;
    logic               last_reg, last_next;
    ljfs_out_t          out_reg, out_next;

    // table, multiplier and divider hookup
    logic          mem_wr;
    logic [AW-1:0] mem_wr_addr;
    ljfs_atom_t    mem_wr_data;
    ljfs_atom_t    rd_atom;
    logic          mul_start;
    logic [63:0]   mul_a;
    logic [63:0]   mul_b;
    ljfs_mul_sts_t mul_sts;
    logic [127:0]  mul_prod;
    logic          div_start;
    logic          div_done;
    logic [63:0]   div_quo;

    // helper values
    logic signed [31:0] atom_crd [3];
    logic signed [32:0] diff [3];
    logic [31:0]        dmag [3];
    logic [47:0]        c6_mag;
    logic [47:0]        c12_mag;
    logic               pow_clamp;
    logic [63:0]        pow_val;
    logic signed [63:0] pow_sgn;
    logic               frc_clamp;
    logic [63:0]        frc_val;
    logic signed [63:0] term;
    ljfs_sat_t          s6, s12, set, sg, sa3, sak;
    logic [CW-1:0]      ncnt;
    logic [CW-1:0]      idx_inc;
    logic [65:0]        r2_sum;

    ljfs_atom_mem #(
        .DEPTH (MAX_ATOMS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_atom)
    );

    ljfs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sts   (mul_sts),
        .prod  (mul_prod)
    );

    ljfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (r2_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ATOM_COUNT))
        begin
            atom_count_reg <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATOM_COUNT) ? 32'(atom_count_reg) : 32'd0;

    // load path straight into the table
    assign mem_wr      = (state_reg == ST_IDLE) && item.valid
                         && (item.data.operation == OP_LOAD)
                         && (int'(item.data.atom_index) < MAX_ATOMS);
    assign mem_wr_addr = AW'(item.data.atom_index);
    assign mem_wr_data = '{x: item.data.pos_x, y: item.data.pos_y, z: item.data.pos_z,
                           c6: item.data.coef_c6, c12: item.data.coef_c12};

    // arithmetic around the shared units
    always_comb
    begin
        atom_crd[0] = rd_atom.x;
        atom_crd[1] = rd_atom.y;
        atom_crd[2] = rd_atom.z;
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = 33'(atom_crd[k]) - 33'(probe_reg[k]);
            dmag[k] = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
        end
        c6_mag  = c6_reg[47] ? 48'(-c6_reg) : c6_reg;
        c12_mag = c12_reg[47] ? 48'(-c12_reg) : c12_reg;
        // power step: (m * ir2) >> 31 clamped
        pow_clamp = |mul_prod[127:94];
        pow_val   = pow_clamp ? MAGMAX : mul_prod[94:31];
        pow_sgn   = (step_reg < 4'd3) ? (c6_reg[47] ? -$signed(pow_val) : $signed(pow_val))
                                      : (c12_reg[47] ? -$signed(pow_val) : $signed(pow_val));
        // force step: (|G| * q) >> 40 clamped
        frc_clamp = |mul_prod[127:103];
        frc_val   = frc_clamp ? MAGMAX : mul_prod[103:40];
        term      = fneg_reg ? -$signed(fm_reg) : $signed(fm_reg);
        s6        = sat64(68'(e6_reg) * 68'sd6);
        s12       = sat64(68'(e12_reg) * 68'sd12);
        set       = sat64(68'(e12_reg) - 68'(e6_reg));
        sg        = sat64(68'(m6_reg) - 68'(m12_reg));
        sa3       = sat64(68'(acc_reg[3]) + 68'(et_reg));
        sak       = sat64(68'(acc_reg[k_reg]) + 68'(term));
        r2_sum    = 66'(r2_reg) + 66'(mul_prod[63:0]);
        ncnt      = (int'(atom_count_reg) < MAX_ATOMS) ? CW'(atom_count_reg)
                                                        : CW'(MAX_ATOMS);
        idx_inc   = idx_reg + CW'(1);
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        probe_next     = probe_reg;
        dm_next        = dm_reg;
        dneg_next      = dneg_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        c6_next        = c6_reg;
        c12_next       = c12_reg;
        r2_next        = r2_reg;
        ir2_next       = ir2_reg;
        pm_next        = pm_reg;
        e6_next        = e6_reg;
        e12_next       = e12_reg;
        m6_next        = m6_reg;
        m12_next       = m12_reg;
        et_next        = et_reg;
        gm_next        = gm_reg;
        gneg_next      = gneg_reg;
        q_next         = q_reg;
        fm_next        = fm_reg;
        fneg_next      = fneg_reg;
        sat_next       = sat_reg;
        last_next      = last_reg;
        mul_start      = 1'b0;
        mul_a          = pm_reg;
        mul_b          = ir2_reg;
        div_start      = 1'b0;

        // result taken downstream
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && (item.data.operation == OP_QUERY))
                begin
                    probe_next[0] = item.data.pos_x;
                    probe_next[1] = item.data.pos_y;
                    probe_next[2] = item.data.pos_z;
                    last_next     = item.data.last_query;
                    sat_next      = 1'b0;
                    for (int k = 0; k < 4; k++)
                    begin
                        acc_next[k] = '0;
                    end
                    idx_next   = '0;
                    cnt_next   = ncnt;
                    state_next = (ncnt == '0) ? ST_OUT : ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dm_next[k]   = dmag[k];
                    dneg_next[k] = diff[k][32];
                end
                c6_next    = rd_atom.c6;
                c12_next   = rd_atom.c12;
                r2_next    = R2SAFE;
                k_next     = 2'd0;
                wait_next  = 1'b0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                mul_a = 64'(dm_reg[k_reg]);
                mul_b = 64'(dm_reg[k_reg]);
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mul_sts.done)
                begin
                    wait_next = 1'b0;
                    r2_next   = r2_sum[64] ? '1 : r2_sum[63:0];
                    if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_DIV;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ST_DIV:
            begin
                if (!wait_reg)
                begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done)
                begin
                    wait_next  = 1'b0;
                    ir2_next   = div_quo;
                    pm_next    = {c6_mag, 16'd0};
                    step_next  = 4'd0;
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mul_sts.done)
                begin
                    wait_next = 1'b0;
                    sat_next  = sat_reg | pow_clamp;
                    step_next = step_reg + 4'd1;
                    pm_next   = pow_val;
                    if (step_reg == 4'd2)
                    begin
                        e6_next = pow_sgn;
                        pm_next = {c12_mag, 16'd0};
                    end else if (step_reg == 4'd8)
                    begin
                        e12_next   = pow_sgn;
                        state_next = ST_GC1;
                    end
                end
            end
            ST_GC1:
            begin
                m6_next    = s6.val;
                m12_next   = s12.val;
                et_next    = set.val;
                sat_next   = sat_reg | s6.clamp | s12.clamp | set.clamp;
                state_next = ST_GC2;
            end
            ST_GC2:
            begin
                gneg_next   = sg.val[63];
                gm_next     = sg.val[63] ? 64'(-sg.val) : sg.val;
                acc_next[3] = sa3.val;
                sat_next    = sat_reg | sg.clamp | sa3.clamp;
                k_next      = 2'd0;
                state_next  = ST_QM;
            end
            ST_QM:
            begin
                mul_a = 64'(dm_reg[k_reg]);
                mul_b = ir2_reg;
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mul_sts.done)
                begin
                    wait_next  = 1'b0;
                    q_next     = 64'(mul_prod[63:7]);
                    state_next = ST_FM;
                end
            end
            ST_FM:
            begin
                mul_a = gm_reg;
                mul_b = q_reg;
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mul_sts.done)
                begin
                    wait_next  = 1'b0;
                    fm_next    = frc_val;
                    fneg_next  = gneg_reg ^ dneg_reg[k_reg];
                    sat_next   = sat_reg | frc_clamp;
                    state_next = ST_FA;
                end
            end
            ST_FA:
            begin
                acc_next[k_reg] = sak.val;
                sat_next        = sat_reg | sak.clamp;
                if (k_reg == 2'd2)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cnt_reg) ? ST_OUT : ST_RD;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_QM;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next.force_x    = acc_reg[0][63:16];
                    out_next.force_y    = acc_reg[1][63:16];
                    out_next.force_z    = acc_reg[2][63:16];
                    out_next.energy     = acc_reg[3][63:16];
                    out_next.last_point = last_reg;
                    out_next.saturated  = sat_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        dm_reg    <= dm_next;
        dneg_reg  <= dneg_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        step_reg  <= step_next;
        c6_reg    <= c6_next;
        c12_reg   <= c12_next;
        r2_reg    <= r2_next;
        ir2_reg   <= ir2_next;
        pm_reg    <= pm_next;
        e6_reg    <= e6_next;
        e12_reg   <= e12_next;
        m6_reg    <= m6_next;
        m12_reg   <= m12_next;
        et_reg    <= et_next;
        gm_reg    <= gm_next;
        gneg_reg  <= gneg_next;
        q_reg     <= q_next;
        fm_reg    <= fm_next;
        fneg_reg  <= fneg_next;
        sat_reg   <= sat_next;
        last_reg  <= last_next;
        out_reg   <= out_next;
    end

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // checks
    `LJFS_ASSERT_SAME(a_idle_mul_quiet, state_reg == ST_IDLE, !mul_sts.busy, "multiplier busy while idle")
    `LJFS_ASSERT_NEXT(a_out_loads, (state_reg == ST_OUT) && (!result.valid || result.ready), result.valid && (state_reg == ST_IDLE), "result not presented")
    `LJFS_ASSERT_SAME(a_rd_in_range, state_reg == ST_RD, idx_reg < cnt_reg, "atom index past count")
    `LJFS_ASSERT_SAME(a_div_done_state, div_done, (state_reg == ST_DIV) && wait_reg, "divider done outside divide")

endmodule
